FILE: hdl/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg: shared constants and types for the LFU cache table
// Table size, counter width, derived index widths and field constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int COUNT_BITS  = 16;

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(MAX_ENTRIES + 1);
    localparam int LEAVES  = 1 << IDX_W;
    localparam int SKEY_W  = COUNT_BITS + RANK_W;

    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int DATA_W  = KEY_W + VAL_W;

    localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [VAL_W-1:0]      MISS_DATA = '1;

    // Command codes carried in s_tuser
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Result flag positions in m_tuser
    localparam int USER_HIT   = 0;
    localparam int USER_EVICT = 1;

    // One node of the victim selection tree
    typedef struct packed {
        logic              valid;
        logic [SKEY_W-1:0] skey;
        logic [IDX_W-1:0]  idx;
    } node_t;

endpackage

`default_nettype wire

FILE: hdl/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table: fully associative key/value cache with LFU replacement
// Pipeline: an accepted item moves from the input register to the result
//   register, which loads whenever it is empty or being drained.
// Throughput: one item per cycle while the result side does not stall; the
//   only loop is the table state, which is read and rewritten between the
//   input register and the result register.
// Reset: synchronous, active low; clears all valid bits and the occupancy,
//   empties both pipeline registers and sets the capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table
    import lct_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Capacity register write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CAP_W-1:0]  cfg_data,     // capacity_in_use
    // Request items
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,      // [31:0] lookup_key, [63:32] store_value
    input  wire logic              s_tuser,      // [0] cmd
    // Result items
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,      // [31:0] read_data, [63:32] evicted_key
    output logic [1:0]             m_tuser       // [0] hit, [1] evicted
);

    // ------------------------------------------------------------------
    // Configuration: always ready; unenforced, the user must see that writes only arrive while idle
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] cap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register feeds the result register whenever
    // the result register is empty or being drained this cycle
    // ------------------------------------------------------------------
    logic             in_valid_reg;
    logic             in_cmd_reg;
    logic [KEY_W-1:0] in_key_reg;
    logic [VAL_W-1:0] in_val_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: hold while stalled, take a new item when the slot frees
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg <= s_tuser;
            in_key_reg <= s_tdata[KEY_W-1:0];
            in_val_reg <= s_tdata[DATA_W-1:KEY_W];
        end
    end

    // ------------------------------------------------------------------
    // Table state
    // ------------------------------------------------------------------
    logic                  valid_reg [MAX_ENTRIES];
    logic [KEY_W-1:0]      key_reg   [MAX_ENTRIES];
    logic [VAL_W-1:0]      value_reg [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] count_reg [MAX_ENTRIES];
    logic [RANK_W-1:0]     rank_reg  [MAX_ENTRIES];
    logic [OCC_W-1:0]      occ_reg;

    logic                  valid_next [MAX_ENTRIES];
    logic [KEY_W-1:0]      key_next   [MAX_ENTRIES];
    logic [VAL_W-1:0]      value_next [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] count_next [MAX_ENTRIES];
    logic [RANK_W-1:0]     rank_next  [MAX_ENTRIES];
    logic [OCC_W-1:0]      occ_next;

    // ------------------------------------------------------------------
    // Parallel key compare. Valid keys are unique, so at most one match
    // and the OR of the masked fields gives the hit entry directly.
    // ------------------------------------------------------------------
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [VAL_W-1:0]  hit_value;
    logic [RANK_W-1:0] hit_rank;

    always_comb begin
        hit       = 1'b0;
        hit_idx   = '0;
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid_reg[i] && key_reg[i] == in_key_reg) begin
                hit       = 1'b1;
                hit_idx   = hit_idx | IDX_W'(i);
                hit_value = hit_value | value_reg[i];
                hit_rank  = hit_rank | rank_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Victim selection: binary tree over {count, inverted rank}; the
    // smallest key is the lowest count, ties going to the oldest entry.
    // Node n has children 2n and 2n+1, leaves sit at LEAVES+i.
    // ------------------------------------------------------------------
    node_t node [2*LEAVES];

    always_comb begin
        node[0] = '0;
        for (int i = 0; i < LEAVES; i++) begin
            node[LEAVES+i] = '0;
            if (i < MAX_ENTRIES) begin
                node[LEAVES+i].valid = valid_reg[i];
                node[LEAVES+i].skey  = {count_reg[i], ~rank_reg[i]};
                node[LEAVES+i].idx   = IDX_W'(i);
            end
        end
        for (int n = LEAVES - 1; n >= 1; n--) begin
            if (node[2*n].valid &&
                (!node[2*n+1].valid || node[2*n].skey <= node[2*n+1].skey)) begin
                node[n] = node[2*n];
            end else begin
                node[n] = node[2*n+1];
            end
        end
    end

    logic [IDX_W-1:0] victim_idx;
    logic             victim_found;
    logic [KEY_W-1:0] victim_key;

    assign victim_idx   = node[1].idx;
    assign victim_found = node[1].valid;

    always_comb begin
        victim_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IDX_W'(i) == victim_idx) begin
                victim_key = key_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Decode the operation
    // ------------------------------------------------------------------
    logic [OCC_W-1:0] cap_eff;
    logic             cap_zero;
    logic             do_touch;
    logic             do_write;
    logic             do_insert_req;
    logic             do_evict;

    always_comb begin
        if (int'(cap_reg) > MAX_ENTRIES) begin
            cap_eff = OCC_W'(MAX_ENTRIES);
        end else begin
            cap_eff = OCC_W'(cap_reg);
        end
    end

    assign cap_zero      = (cap_reg == '0);
    // Hit on get, or hit on put with room allowed: bump and make most recent
    assign do_touch      = fire && hit && (in_cmd_reg == CMD_GET || !cap_zero);
    assign do_write      = fire && hit && in_cmd_reg == CMD_PUT && !cap_zero;
    assign do_insert_req = fire && !hit && in_cmd_reg == CMD_PUT && !cap_zero;
    assign do_evict      = do_insert_req && (occ_reg >= cap_eff) && victim_found;

    // Lowest free slot once the victim (if any) has been dropped
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             do_insert;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i] || (do_evict && IDX_W'(i) == victim_idx)) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign do_insert = do_insert_req && free_found;

    // ------------------------------------------------------------------
    // Next table state
    // ------------------------------------------------------------------
    logic [RANK_W-1:0] victim_rank;

    always_comb begin
        victim_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IDX_W'(i) == victim_idx) begin
                victim_rank = rank_reg[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_next[i] = valid_reg[i];
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];

            if (do_touch && valid_reg[i]) begin
                if (IDX_W'(i) == hit_idx) begin
                    rank_next[i] = '0;
                    if (count_reg[i] != COUNT_MAX) begin
                        count_next[i] = count_reg[i] + COUNT_ONE;
                    end
                    if (do_write) begin
                        value_next[i] = in_val_reg;
                    end
                end else if (rank_reg[i] < hit_rank) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end

            if (do_insert_req) begin
                if (do_evict && IDX_W'(i) == victim_idx) begin
                    valid_next[i] = 1'b0;
                end else if (valid_reg[i]) begin
                    // Drop above the victim and age by one cancel out
                    if (!(do_evict && rank_reg[i] > victim_rank)) begin
                        if (do_insert) begin
                            rank_next[i] = rank_reg[i] + RANK_W'(1);
                        end
                    end else if (!do_insert) begin
                        rank_next[i] = rank_reg[i] - RANK_W'(1);
                    end
                end
                if (do_insert && IDX_W'(i) == free_idx) begin
                    valid_next[i] = 1'b1;
                    key_next[i]   = in_key_reg;
                    value_next[i] = in_val_reg;
                    count_next[i] = COUNT_ONE;
                    rank_next[i]  = '0;
                end
            end
        end
    end

    always_comb begin
        occ_next = occ_reg;
        if (do_evict && !do_insert) begin
            occ_next = occ_reg - OCC_W'(1);
        end else if (do_insert && !do_evict) begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            occ_reg <= occ_next;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            key_reg[i]   <= key_next[i];
            value_reg[i] <= value_next[i];
            count_reg[i] <= count_next[i];
            rank_reg[i]  <= rank_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on fire, drop valid once taken
    // ------------------------------------------------------------------
    logic             res_hit_reg;
    logic             res_evict_reg;
    logic [VAL_W-1:0] res_data_reg;
    logic [KEY_W-1:0] res_ekey_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_hit_reg   <= hit;
            res_evict_reg <= do_evict;
            res_data_reg  <= (hit && in_cmd_reg == CMD_GET) ? hit_value : MISS_DATA;
            res_ekey_reg  <= do_evict ? victim_key : '0;
        end
    end

    assign m_tvalid             = out_valid_reg;
    assign m_tdata              = {res_ekey_reg, res_data_reg};
    assign m_tuser[USER_HIT]    = res_hit_reg;
    assign m_tuser[USER_EVICT]  = res_evict_reg;

endmodule

`default_nettype wire

FILE: hdl/lct_checker.sv
// ----------------------------------------------------------------------------
// lct_checker: port-level checks for the LFU cache table
// Watches the result channel for stalls, pointless flags and stray items.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_checker
    import lct_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic [1:0]        m_tuser
);

    // Hold a stalled result item unchanged
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // An eviction only happens on a miss
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_EVICT] |-> !m_tuser[USER_HIT])
        else $error("eviction reported on a hit");

    // No eviction means a zero evicted key
    a_ekey_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_EVICT] |-> m_tdata[DATA_W-1:KEY_W] == '0)
        else $error("evicted key set without eviction");

    // A fresh result traces back to an accepted request through the input and result registers
    a_no_stray: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result item without a request");

endmodule

bind lfu_cache_table lct_checker u_lct_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LFU cache table
// Drives get and put requests through the request stream and runs a
// behavioural copy of the cache beside the block. Every result item is
// compared with the oldest prediction. The bench covers directed corner
// cases, a hot-key run that checks frequency ordering and random phases at
// several capacities, with random stalls and a long hold-off on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import lct_pkg::*;
();

    localparam int HOLD_CYCLES  = 60;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 6;    // settle time after the last result, as margin
    localparam int POOL_SIZE    = 24;
    localparam int HOT_GETS     = 12;   // uses piled on the hot key

    // One predicted result item
    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] read_data;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the cache table and the queue of predictions
    // ------------------------------------------------------------------------
    class lfu_scoreboard;
        bit                  valid_q [MAX_ENTRIES];
        bit [KEY_W-1:0]      key_q   [MAX_ENTRIES];
        bit [VAL_W-1:0]      val_q   [MAX_ENTRIES];
        bit [COUNT_BITS-1:0] uses_q  [MAX_ENTRIES];
        int                  rank_q  [MAX_ENTRIES];
        int                  fill;
        int                  capacity;
        cache_result_t       pending_q[$];
        int                  errors;
        int                  checked;
        int                  evictions;

        function new();
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_q[i] = 1'b0;
            end
            fill      = 0;
            capacity  = int'(CAP_RESET);
            errors    = 0;
            checked   = 0;
            evictions = 0;
        endfunction

        function void set_capacity(bit [CAP_W-1:0] v);
            capacity = int'(v);
        endfunction

        function int find_slot(bit [KEY_W-1:0] key);
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (valid_q[i] && key_q[i] == key) return i;
            end
            return -1;
        endfunction

        // Make slot s the most recent entry
        function void promote(int s);
            int r;
            r = rank_q[s];
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (valid_q[i] && rank_q[i] < r) rank_q[i]++;
            end
            rank_q[s] = 0;
        endfunction

        // Add one use, holding at the counter ceiling
        function void add_use(int s);
            if (uses_q[s] != COUNT_MAX) uses_q[s]++;
        endfunction

        // Lowest use count wins; among equals the least recent one
        function int lfu_victim();
            int v;
            v = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (!valid_q[i]) continue;
                if (v < 0 || uses_q[i] < uses_q[v] ||
                    (uses_q[i] == uses_q[v] && rank_q[i] > rank_q[v]))
                    v = i;
            end
            return v;
        endfunction

        function void evict_slot(int s);
            int r;
            r = rank_q[s];
            valid_q[s] = 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (valid_q[i] && rank_q[i] > r) rank_q[i]--;
            end
            if (fill > 0) fill--;
        endfunction

        // Predict the result of an accepted request and update the shadow table
        function void note_request(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
            cache_result_t r;
            int            cap;
            int            s;
            int            v;
            int            slot;
            cap           = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
            s             = find_slot(key);
            r.hit         = (s >= 0);
            r.read_data   = MISS_DATA;
            r.evicted     = 1'b0;
            r.evicted_key = '0;
            if (cmd == CMD_GET) begin
                if (s >= 0) begin
                    r.read_data = val_q[s];
                    add_use(s);
                    promote(s);
                end
            end else if (cap != 0) begin
                if (s >= 0) begin
                    val_q[s] = value;
                    add_use(s);
                    promote(s);
                end else begin
                    if (fill >= cap) begin
                        v = lfu_victim();
                        if (v >= 0) begin
                            r.evicted     = 1'b1;
                            r.evicted_key = key_q[v];
                            evict_slot(v);
                        end
                    end
                    slot = -1;
                    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
                        if (!valid_q[i]) slot = i;
                    end
                    if (slot >= 0) begin
                        for (int j = 0; j < MAX_ENTRIES; j++) begin
                            if (valid_q[j]) rank_q[j]++;
                        end
                        valid_q[slot] = 1'b1;
                        key_q[slot]   = key;
                        val_q[slot]   = value;
                        uses_q[slot]  = COUNT_ONE;
                        rank_q[slot]  = 0;
                        fill++;
                    end
                end
            end
            pending_q.push_back(r);
        endfunction

        // Compare an accepted result item with the oldest prediction
        function void check_result(logic hit, logic [VAL_W-1:0] rd, logic ev,
                                   logic [KEY_W-1:0] ek);
            cache_result_t want;
            if (pending_q.size() == 0) begin
                $error("result item with no request outstanding");
                errors++;
                return;
            end
            want = pending_q[0];
            pending_q.delete(0);
            checked++;
            if (want.evicted) evictions++;
            if (hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, hit);
                errors++;
            end
            if (rd !== want.read_data) begin
                $error("read_data: expected %h, got %h", want.read_data, rd);
                errors++;
            end
            if (ev !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, ev);
                errors++;
            end
            if (ek !== want.evicted_key) begin
                $error("evicted_key: expected %h, got %h", want.evicted_key, ek);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data  = CAP_RESET;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;      // [31:0] lookup_key, [63:32] store_value
    logic              s_tuser   = CMD_GET; // [0] cmd
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;             // [31:0] read_data, [63:32] evicted_key
    logic [1:0]        m_tuser;             // [0] hit, [1] evicted

    lfu_scoreboard     sb;
    bit                tx_idle   = 1'b1;    // sender may insert gaps
    bit                rx_idle   = 1'b1;    // receiver may stall
    bit                hold_off  = 1'b0;    // request for one long receiver stall
    int                sent      = 0;
    int                cap_writes = 0;
    bit [KEY_W-1:0]    key_pool [POOL_SIZE];

    lfu_cache_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: values read here are those sampled at the clock edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[KEY_W-1:0], s_tdata[DATA_W-1:KEY_W]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser[USER_HIT], m_tdata[VAL_W-1:0],
                                m_tuser[USER_EVICT], m_tdata[DATA_W-1:VAL_W]);
        end
    end

    // Receiver: random stalls, or one long hold-off when asked for
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= !(rx_idle && ($urandom_range(99) < 21));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // Offer one request item; gaps go in front so valid never drops mid-step
    task automatic send_req(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
        while (tx_idle && ($urandom_range(99) < 21)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, key};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Drop valid and hold until every predicted result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the capacity register; call only with the table drained
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(v);
        cap_writes++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int span);
        if ($urandom_range(99) < 80) return key_pool[$urandom_range(span - 1)];
        return $urandom;
    endfunction

    // Random gets and puts over the first span keys of the pool, plus noise keys
    task automatic random_reqs(input int count, input int span);
        logic [KEY_W-1:0] key;
        logic             cmd;
        for (int n = 0; n < count; n++) begin
            key = pick_key(span);
            cmd = ($urandom_range(1) == 0) ? CMD_GET : CMD_PUT;
            send_req(cmd, key, $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int               phase_cap [10];
        int               span;
        logic [KEY_W-1:0] hot_key;

        sb = new();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: misses, extreme keys and values, a stored value of -1
        send_req(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_req(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_req(CMD_PUT, 32'h8000_0000, 32'h8000_0000);
        send_req(CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678);
        send_req(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // Capacity lowered below occupancy: each new key evicts exactly one
        write_capacity(CAP_W'(2));
        send_req(CMD_PUT, 32'h0000_0001, 32'h0000_0001);
        send_req(CMD_PUT, 32'h0000_0002, 32'h0000_0002);
        send_req(CMD_PUT, 32'h0000_0003, 32'h0000_0003);
        wait_drained();

        // Zero capacity: puts change nothing, gets still hit
        write_capacity(CAP_W'(0));
        send_req(CMD_PUT, 32'h8000_0000, 32'h0000_0005);
        send_req(CMD_PUT, 32'h1234_5678, 32'h0000_0006);
        send_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        wait_drained();

        // Capacity above table size: fill to the top, then evict by recency tie
        write_capacity(CAP_W'(31));
        for (int i = 0; i < 14; i++) send_req(CMD_PUT, 32'h100 + i, $urandom);

        // Frequency ordering: pile uses on one key, then a new key must evict
        // a single-use entry rather than the hot one
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hot_key = 32'hA5A5_5A5A;
        send_req(CMD_PUT, hot_key, 32'h0BAD_F00D);
        repeat (HOT_GETS) send_req(CMD_GET, hot_key, $urandom);
        send_req(CMD_PUT, 32'h200, 32'h0000_0200);
        repeat (5) send_req(CMD_GET, hot_key, $urandom);
        send_req(CMD_PUT, 32'h201, 32'h0000_0201);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_drained();

        // Random phases over a spread of capacities
        phase_cap = '{16, 4, 1, 31, 0, 8, 2, 16, 0, 0};
        phase_cap[8] = $urandom_range(1, 31);
        phase_cap[9] = $urandom_range(1, 31);
        for (int p = 0; p < 10; p++) begin
            write_capacity(CAP_W'(phase_cap[p]));
            span = (phase_cap[p] + 6 > POOL_SIZE) ? POOL_SIZE : phase_cap[p] + 6;
            case (p)
                3: begin
                    // long receiver hold-off while requests keep coming
                    random_reqs(10, span);
                    hold_off = 1'b1;
                    random_reqs(90, span);
                end
                4: begin
                    random_reqs(40, span);
                end
                5: begin
                    // stretch with no idling on either side
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                    random_reqs(100, span);
                    tx_idle = 1'b1;
                    rx_idle = 1'b1;
                end
                7: begin
                    // sender pauses until the table has drained
                    random_reqs(50, span);
                    wait_drained();
                    random_reqs(50, span);
                end
                default: begin
                    random_reqs(100, span);
                end
            endcase
            wait_drained();
        end

        $display("%0d requests sent, %0d results checked, %0d evictions, %0d capacity writes",
                 sent, sb.checked, sb.evictions, cap_writes);
        $display("covered zero and oversize capacity, shrinking below occupancy, hot-key eviction");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
